### sv/v3a_pkg.sv
`default_nettype none
package v3a_pkg;

  localparam int DW     = 32;          // operand and result width
  localparam int FB     = 16;          // fraction bits
  localparam int ACT_W  = 4;
  localparam int NW     = DW + FB;     // divider numerator and quotient width
  localparam int SQ_W   = DW;          // root width
  localparam int SQI_W  = 2 * DW;      // radicand width
  localparam int SAT_W  = 2 * DW + 3;  // widest value handed to saturation
  localparam int PIPE   = 2 + SQ_W + NW;
  localparam int LAT    = PIPE + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 4'd0,
    ACT_SUB   = 4'd1,
    ACT_ADDS  = 4'd2,
    ACT_SUBS  = 4'd3,
    ACT_MULS  = 4'd4,
    ACT_DIVS  = 4'd5,
    ACT_CROSS = 4'd6,
    ACT_DOT   = 4'd7,
    ACT_LEN   = 4'd8,
    ACT_NORM  = 4'd9
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic signed [DW-1:0]  a_x;
    logic signed [DW-1:0]  a_y;
    logic signed [DW-1:0]  a_z;
    logic signed [DW-1:0]  b_x;
    logic signed [DW-1:0]  b_y;
    logic signed [DW-1:0]  b_z;
    logic signed [DW-1:0]  scale;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0]  r_x;
    logic signed [DW-1:0]  r_y;
    logic signed [DW-1:0]  r_z;
    logic signed [DW-1:0]  scalar_out;
    logic                  fault;
  } rsp_t;

  // per-lane result after the second stage
  typedef struct packed {
    logic signed [DW-1:0]  res;
    logic [NW-1:0]         num;
    logic                  neg;
  } lane_t;

  // everything that rides alongside the square root and the dividers
  typedef struct packed {
    logic [ACT_W-1:0]      act;
    lane_t [2:0]           lane;
    logic [DW-1:0]         sabs;
    logic [DW-1:0]         sc;
    logic                  fault;
  } side_t;

  function automatic logic [DW-1:0] sat_fn(input logic signed [SAT_W-1:0] v);
    logic ovf;
    ovf = !((&v[SAT_W-1:DW-1]) || !(|v[SAT_W-1:DW-1]));
    if (!ovf) return v[DW-1:0];
    else if (v[SAT_W-1]) return {1'b1, {(DW-1){1'b0}}};
    else return {1'b0, {(DW-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

### sv/vec3_arith_unit_top.sv
// Throughput: one request per cycle; busy never rises and the receiver cannot stall.
// The 32-stage square root and three 48-stage dividers set the latency; every
// operation runs the full pipeline so results leave in request order.
// Reset (rst_ni low, asynchronous) clears the valid line; the data path is not reset.
`default_nettype none
module vec3_arith_unit_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire v3a_pkg::req_t  req_i,
  output logic                valid_o,
  output v3a_pkg::rsp_t       rsp_o
);
  import v3a_pkg::*;

  logic                    accept;
  logic signed [DW-1:0]    av [3];
  logic signed [DW-1:0]    bv [3];
  logic signed [2*DW-1:0]  prod [3];
  lane_t [2:0]             lanes;

  logic [ACT_W-1:0]        act1_q, act2_q;
  logic signed [DW-1:0]    s1_q;
  logic                    azero1_q;
  logic [DW-1:0]           sabs2_q, sc2_q;
  logic [SQI_W-1:0]        sq2_q;
  logic                    flt2_q;
  logic signed [2*DW+1:0]  dsum;
  side_t                   side2;

  logic [SQ_W-1:0]         len;
  side_t                   da_q [SQ_W];
  side_t                   db_q [NW];
  logic [SQ_W-1:0]         lb_q [NW];
  logic [DW-1:0]           dsr;
  logic [NW-1:0]           quo [3];
  logic                    vld_q [PIPE];
  logic                    valid_q;
  rsp_t                    rsp_d, rsp_q;
  logic [DW-1:0]           rv [3];
  logic signed [NW:0]      sv [3];
  side_t                   sb;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign av[0] = req_i.a_x;
  assign av[1] = req_i.a_y;
  assign av[2] = req_i.a_z;
  assign bv[0] = req_i.b_x;
  assign bv[1] = req_i.b_y;
  assign bv[2] = req_i.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane u_lane (
      .clk_i  (clk_i),
      .act_i  (req_i.action),
      .ai_i   (av[i]),
      .aj_i   (av[(i+1)%3]),
      .ak_i   (av[(i+2)%3]),
      .bi_i   (bv[i]),
      .bj_i   (bv[(i+1)%3]),
      .bk_i   (bv[(i+2)%3]),
      .s_i    (req_i.scale),
      .prod_o (prod[i]),
      .lane_o (lanes[i])
    );
  end

  always_ff @(posedge clk_i) begin
    act1_q   <= req_i.action;
    s1_q     <= req_i.scale;
    azero1_q <= (req_i.a_x == '0) && (req_i.a_y == '0) && (req_i.a_z == '0);
  end

  // merge the lane products: dot product and squared length
  assign dsum = (2*DW+2)'(prod[0]) + (2*DW+2)'(prod[1]) + (2*DW+2)'(prod[2]);

  always_ff @(posedge clk_i) begin
    act2_q  <= act1_q;
    sabs2_q <= s1_q[DW-1] ? DW'(-s1_q) : s1_q;
    sq2_q   <= dsum[SQI_W-1:0];
    sc2_q   <= (act1_q == ACT_DOT) ? sat_fn(SAT_W'(dsum >>> FB)) : '0;
    flt2_q  <= ((act1_q == ACT_DIVS) && (s1_q == '0)) ||
               ((act1_q == ACT_NORM) && azero1_q);
  end

  always_comb begin
    side2.act   = act2_q;
    side2.lane  = lanes;
    side2.sabs  = sabs2_q;
    side2.sc    = sc2_q;
    side2.fault = flt2_q;
  end

  v3a_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (sq2_q),
    .root_o (len)
  );

  // hold the side data while the root forms, then while the quotients form
  always_ff @(posedge clk_i) begin
    da_q[0] <= side2;
    for (int k = 1; k < SQ_W; k++) da_q[k] <= da_q[k-1];
    db_q[0] <= da_q[SQ_W-1];
    lb_q[0] <= len;
    for (int k = 1; k < NW; k++) begin
      db_q[k] <= db_q[k-1];
      lb_q[k] <= lb_q[k-1];
    end
  end

  assign dsr = (da_q[SQ_W-1].act == ACT_NORM) ? len : da_q[SQ_W-1].sabs;

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div u_div (
      .clk_i (clk_i),
      .num_i (da_q[SQ_W-1].lane[i].num),
      .dsr_i (dsr),
      .quo_o (quo[i])
    );
  end

  always_comb begin
    sb = db_q[NW-1];
    for (int i = 0; i < 3; i++) begin
      sv[i] = sb.lane[i].neg ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      rv[i] = sb.lane[i].res;
    end
    rsp_d.scalar_out = sb.sc;
    rsp_d.fault      = sb.fault;
    case (sb.act)
      ACT_DIVS, ACT_NORM: begin
        for (int i = 0; i < 3; i++) rv[i] = sb.fault ? '0 : sat_fn(SAT_W'(sv[i]));
      end
      ACT_LEN: begin
        rsp_d.scalar_out = sat_fn(SAT_W'({1'b0, lb_q[NW-1]}));
      end
      default: begin
      end
    endcase
    rsp_d.r_x = rv[0];
    rsp_d.r_y = rv[1];
    rsp_d.r_z = rv[2];
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE; k++) vld_q[k] <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k < PIPE; k++) vld_q[k] <= vld_q[k-1];
      valid_q <= vld_q[PIPE-1];
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule
`default_nettype wire

### sv/v3a_lane.sv
`default_nettype none
module v3a_lane (
  input  wire logic                         clk_i,
  input  wire logic [v3a_pkg::ACT_W-1:0]    act_i,
  input  wire logic signed [v3a_pkg::DW-1:0] ai_i,
  input  wire logic signed [v3a_pkg::DW-1:0] aj_i,
  input  wire logic signed [v3a_pkg::DW-1:0] ak_i,
  input  wire logic signed [v3a_pkg::DW-1:0] bi_i,
  input  wire logic signed [v3a_pkg::DW-1:0] bj_i,
  input  wire logic signed [v3a_pkg::DW-1:0] bk_i,
  input  wire logic signed [v3a_pkg::DW-1:0] s_i,
  output logic signed [2*v3a_pkg::DW-1:0]   prod_o,
  output v3a_pkg::lane_t                    lane_o
);
  import v3a_pkg::*;

  logic signed [DW-1:0]    ma, mb;
  logic signed [DW:0]      sum_d;
  logic signed [2*DW-1:0]  p_q, q_q;
  logic signed [DW:0]      sum_q;
  logic [ACT_W-1:0]        act_q;
  logic signed [DW-1:0]    a_q, s_q;
  logic signed [2*DW:0]    diff;
  logic [DW-1:0]           a_abs;
  lane_t                   lane_d, lane_q;

  // first multiplier doubles as the cross term, the scale, dot or square product
  always_comb begin
    ma = (act_i == ACT_CROSS) ? aj_i : ai_i;
    case (act_i)
      ACT_CROSS: mb = bk_i;
      ACT_MULS:  mb = s_i;
      ACT_DOT:   mb = bi_i;
      default:   mb = ai_i;
    endcase
    case (act_i)
      ACT_ADD:  sum_d = (DW+1)'(ai_i) + (DW+1)'(bi_i);
      ACT_SUB:  sum_d = (DW+1)'(ai_i) - (DW+1)'(bi_i);
      ACT_ADDS: sum_d = (DW+1)'(ai_i) + (DW+1)'(s_i);
      default:  sum_d = (DW+1)'(ai_i) - (DW+1)'(s_i);
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q   <= ma * mb;
    q_q   <= ak_i * bj_i;
    sum_q <= sum_d;
    act_q <= act_i;
    a_q   <= ai_i;
    s_q   <= s_i;
  end

  always_comb begin
    diff  = (2*DW+1)'(p_q) - (2*DW+1)'(q_q);
    a_abs = a_q[DW-1] ? DW'(-a_q) : a_q;
    case (act_q)
      ACT_ADD, ACT_SUB, ACT_ADDS, ACT_SUBS: lane_d.res = sat_fn(SAT_W'(sum_q));
      ACT_MULS:  lane_d.res = sat_fn(SAT_W'(p_q >>> FB));
      ACT_CROSS: lane_d.res = sat_fn(SAT_W'(diff >>> FB));
      default:   lane_d.res = '0;
    endcase
    lane_d.num = {a_abs, {FB{1'b0}}};
    lane_d.neg = a_q[DW-1] ^ ((act_q == ACT_DIVS) && s_q[DW-1]);
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign prod_o = p_q;
  assign lane_o = lane_q;

endmodule
`default_nettype wire

### sv/v3a_isqrt.sv
`default_nettype none
module v3a_isqrt (
  input  wire logic                      clk_i,
  input  wire logic [v3a_pkg::SQI_W-1:0] rad_i,
  output logic [v3a_pkg::SQ_W-1:0]       root_o
);
  import v3a_pkg::*;

  localparam int RW = SQ_W + 3;

  logic [RW-1:0]    rem_p [SQ_W];
  logic [SQ_W-1:0]  root_p [SQ_W];
  logic [SQI_W-1:0] x_p [SQ_W];
  logic [RW-1:0]    rem_d [SQ_W];
  logic [SQ_W-1:0]  root_d [SQ_W];
  logic [SQI_W-1:0] x_d [SQ_W];
  logic [RW-1:0]    rem_q [SQ_W];
  logic [SQ_W-1:0]  root_q [SQ_W];
  logic [SQI_W-1:0] x_q [SQ_W];
  logic [RW-1:0]    r_sh [SQ_W];
  logic [RW-1:0]    trial [SQ_W];

  // one root bit per stage: bring down two radicand bits, try 4r+1
  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    x_p[0]    = rad_i;
    for (int g = 1; g < SQ_W; g++) begin
      rem_p[g]  = rem_q[g-1];
      root_p[g] = root_q[g-1];
      x_p[g]    = x_q[g-1];
    end
    for (int g = 0; g < SQ_W; g++) begin
      r_sh[g]  = {rem_p[g][RW-3:0], x_p[g][SQI_W-1 -: 2]};
      trial[g] = RW'({root_p[g], 2'b01});
      x_d[g]   = {x_p[g][SQI_W-3:0], 2'b00};
      if (r_sh[g] >= trial[g]) begin
        rem_d[g]  = r_sh[g] - trial[g];
        root_d[g] = {root_p[g][SQ_W-2:0], 1'b1};
      end else begin
        rem_d[g]  = r_sh[g];
        root_d[g] = {root_p[g][SQ_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < SQ_W; g++) begin
      rem_q[g]  <= rem_d[g];
      root_q[g] <= root_d[g];
      x_q[g]    <= x_d[g];
    end
  end

  assign root_o = root_q[SQ_W-1];

endmodule
`default_nettype wire

### sv/v3a_div.sv
`default_nettype none
module v3a_div (
  input  wire logic                   clk_i,
  input  wire logic [v3a_pkg::NW-1:0] num_i,
  input  wire logic [v3a_pkg::DW-1:0] dsr_i,
  output logic [v3a_pkg::NW-1:0]      quo_o
);
  import v3a_pkg::*;

  logic [DW-1:0] rem_p [NW];
  logic [NW-1:0] n_p [NW];
  logic [DW-1:0] d_p [NW];
  logic [DW-1:0] rem_d [NW];
  logic [NW-1:0] n_d [NW];
  logic [DW:0]   r_sh [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] n_q [NW];
  logic [DW-1:0] d_q [NW];

  // restoring division, one quotient bit per stage shifted into the numerator word
  always_comb begin
    rem_p[0] = '0;
    n_p[0]   = num_i;
    d_p[0]   = dsr_i;
    for (int g = 1; g < NW; g++) begin
      rem_p[g] = rem_q[g-1];
      n_p[g]   = n_q[g-1];
      d_p[g]   = d_q[g-1];
    end
    for (int g = 0; g < NW; g++) begin
      r_sh[g] = {rem_p[g], n_p[g][NW-1]};
      if (r_sh[g] >= {1'b0, d_p[g]}) begin
        rem_d[g] = DW'(r_sh[g] - {1'b0, d_p[g]});
        n_d[g]   = {n_p[g][NW-2:0], 1'b1};
      end else begin
        rem_d[g] = r_sh[g][DW-1:0];
        n_d[g]   = {n_p[g][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NW; g++) begin
      rem_q[g] <= rem_d[g];
      n_q[g]   <= n_d[g];
      d_q[g]   <= d_p[g];
    end
  end

  assign quo_o = n_q[NW-1];

endmodule
`default_nettype wire

### sv/v3a_checker.sv
`default_nettype none
module v3a_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire v3a_pkg::req_t req_i,
  input wire logic          valid_o,
  input wire v3a_pkg::rsp_t rsp_o
);
  import v3a_pkg::*;

  // a result only ever follows a request by the fixed latency
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT valid_o)
    else $error("request produced no result");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.fault) |->
      (rsp_o.r_x == '0 && rsp_o.r_y == '0 && rsp_o.r_z == '0 && rsp_o.scalar_out == '0))
    else $error("fault result carries data");

  a_scalar_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.scalar_out != '0) |->
      (rsp_o.r_x == '0 && rsp_o.r_y == '0 && rsp_o.r_z == '0))
    else $error("scalar and vector result both set");

endmodule

bind vec3_arith_unit_top v3a_checker u_v3a_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .req_i   (req_i),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);
`default_nettype wire

### tb/tb_vec3_arith_unit_top.sv
`timescale 1ns / 1ps
module tb_vec3_arith_unit_top;
  import v3a_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNDEF_FIRST = 4'd10;
  localparam logic [ACT_W-1:0] ACT_UNDEF_LAST  = 4'd15;
  localparam int               N_RANDOM        = 750;
  localparam int               DRAIN_CYCLES    = LAT + 20;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  req_t  req_i = '0;
  logic  valid_o;
  rsp_t  rsp_o;

  req_t  pending_reqs[$];
  rsp_t  expected_rsps[$];
  int    mismatches = 0;
  int    sent = 0;
  int    checked = 0;
  int    fault_seen = 0;
  bit    took = 1'b0;
  bit    stim_done = 1'b0;

  vec3_arith_unit_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [DW-1:0] clamp_q(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fff_ffff;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [127:0] wide(input logic [DW-1:0] v);
    return 128'($signed(v));
  endfunction

  // (a << FB) / d, truncated toward zero
  function automatic logic [DW-1:0] q_div(input logic signed [127:0] a,
                                          input logic signed [127:0] d);
    logic signed [127:0] num;
    num = a <<< FB;
    return clamp_q(num / d);
  endfunction

  function automatic logic [DW-1:0] q_cross(input logic [DW-1:0] p, input logic [DW-1:0] q,
                                            input logic [DW-1:0] r, input logic [DW-1:0] s);
    logic signed [127:0] t;
    t = wide(p) * wide(q) - wide(r) * wide(s);
    return clamp_q(t >>> FB);
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic rsp_t vec3_result(input req_t rq);
    rsp_t                r;
    logic signed [127:0] av[3];
    logic signed [127:0] bv[3];
    logic signed [127:0] sv;
    logic signed [127:0] t;
    logic [127:0]        len;
    r = '0;
    av[0] = wide(rq.a_x); av[1] = wide(rq.a_y); av[2] = wide(rq.a_z);
    bv[0] = wide(rq.b_x); bv[1] = wide(rq.b_y); bv[2] = wide(rq.b_z);
    sv = wide(rq.scale);
    case (rq.action)
      ACT_ADD: begin
        r.r_x = clamp_q(av[0] + bv[0]); r.r_y = clamp_q(av[1] + bv[1]);
        r.r_z = clamp_q(av[2] + bv[2]);
      end
      ACT_SUB: begin
        r.r_x = clamp_q(av[0] - bv[0]); r.r_y = clamp_q(av[1] - bv[1]);
        r.r_z = clamp_q(av[2] - bv[2]);
      end
      ACT_ADDS: begin
        r.r_x = clamp_q(av[0] + sv); r.r_y = clamp_q(av[1] + sv); r.r_z = clamp_q(av[2] + sv);
      end
      ACT_SUBS: begin
        r.r_x = clamp_q(av[0] - sv); r.r_y = clamp_q(av[1] - sv); r.r_z = clamp_q(av[2] - sv);
      end
      ACT_MULS: begin
        r.r_x = clamp_q((av[0] * sv) >>> FB); r.r_y = clamp_q((av[1] * sv) >>> FB);
        r.r_z = clamp_q((av[2] * sv) >>> FB);
      end
      ACT_DIVS: begin
        if (sv == 0) r.fault = 1'b1;
        else begin
          r.r_x = q_div(av[0], sv); r.r_y = q_div(av[1], sv); r.r_z = q_div(av[2], sv);
        end
      end
      ACT_CROSS: begin
        r.r_x = q_cross(rq.a_y, rq.b_z, rq.a_z, rq.b_y);
        r.r_y = q_cross(rq.a_z, rq.b_x, rq.a_x, rq.b_z);
        r.r_z = q_cross(rq.a_x, rq.b_y, rq.a_y, rq.b_x);
      end
      ACT_DOT: begin
        t = av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2];
        r.scalar_out = clamp_q(t >>> FB);
      end
      ACT_LEN, ACT_NORM: begin
        t = av[0] * av[0] + av[1] * av[1] + av[2] * av[2];
        len = floor_sqrt(t);
        if (rq.action == ACT_LEN) r.scalar_out = clamp_q($signed(len));
        else if (len == 0) r.fault = 1'b1;
        else begin
          r.r_x = q_div(av[0], $signed(len)); r.r_y = q_div(av[1], $signed(len));
          r.r_z = q_div(av[2], $signed(len));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    mismatches++;
    $display("%0t: result %0d %s got %h want %h", $time, checked, what, got, want);
  endtask

  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'h7fff_ffff - $urandom_range(0, 2);
      2:       return 32'h8000_0000 + $urandom_range(0, 2);
      3:       return '0;
      default: return 32'($signed($urandom_range(0, 32'h003f_ffff)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic req_t random_req();
    req_t rq;
    rq.action = ($urandom_range(0, 19) == 0)
                ? ACT_W'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST))
                : ACT_W'($urandom_range(ACT_ADD, ACT_NORM));
    rq.a_x = pick_operand(); rq.a_y = pick_operand(); rq.a_z = pick_operand();
    rq.b_x = pick_operand(); rq.b_y = pick_operand(); rq.b_z = pick_operand();
    rq.scale = pick_operand();
    return rq;
  endfunction

  // drive on the falling edge; hold the request until it is taken
  always @(negedge clk_i) begin
    int idle_pct;
    case ((sent / 150) % 4)
      1:       idle_pct = 53;
      3:       idle_pct = 21;
      default: idle_pct = 0;
    endcase
    if (rst_ni && (!start || took)) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        req_i <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
    took = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && start && !busy) begin
      expected_rsps.push_back(vec3_result(req_i));
      sent++;
      took = 1'b1;
    end
    if (rst_ni && valid_o) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result r_x", rsp_o.r_x, '0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_o.r_x !== want.r_x) report_mismatch("r_x", rsp_o.r_x, want.r_x);
        if (rsp_o.r_y !== want.r_y) report_mismatch("r_y", rsp_o.r_y, want.r_y);
        if (rsp_o.r_z !== want.r_z) report_mismatch("r_z", rsp_o.r_z, want.r_z);
        if (rsp_o.scalar_out !== want.scalar_out)
          report_mismatch("scalar_out", rsp_o.scalar_out, want.scalar_out);
        if (rsp_o.fault !== want.fault)
          report_mismatch("fault", DW'(rsp_o.fault), DW'(want.fault));
        if (want.fault) fault_seen++;
        checked++;
      end
    end
  end

  initial begin
    req_t rq;
    rq = '{action: ACT_ADD, a_x: 32'h7fff_ffff, a_y: 32'h8000_0000, a_z: 32'h0001_0000,
           b_x: 32'h7fff_ffff, b_y: 32'h8000_0000, b_z: 32'hffff_0000, scale: 32'h0002_8000};
    // every action code, the undefined ones too, on extreme operands, then the two fault cases and single cases
    for (int act = ACT_ADD; act <= ACT_UNDEF_LAST; act++) begin
      rq.action = ACT_W'(act);
      pending_reqs.push_back(rq);
    end
    rq.scale = '0;
    rq.action = ACT_DIVS;
    pending_reqs.push_back(rq);
    rq = '{action: ACT_NORM, default: '0};
    pending_reqs.push_back(rq);
    rq = '{action: ACT_NORM, a_x: 32'h0003_0000, a_y: 32'hfffc_0000, a_z: '0, default: '0};
    pending_reqs.push_back(rq);
    rq.action = ACT_LEN;
    pending_reqs.push_back(rq);
    rq = '{action: ACT_MULS, a_x: 32'h8000_0000, a_y: 32'h8000_0000, a_z: 32'h0000_0001,
           scale: 32'h8000_0000, default: '0};
    pending_reqs.push_back(rq);
    rq = '{action: ACT_DIVS, a_x: 32'h8000_0000, a_y: 32'h7fff_ffff, a_z: 32'hffff_ffff,
           scale: 32'hffff_ffff, default: '0};
    pending_reqs.push_back(rq);
    rq = '{action: ACT_CROSS, a_x: 32'h0001_0000, a_y: 32'h0002_0000, a_z: 32'h0003_0000,
           b_x: 32'h0004_0000, b_y: 32'hfffb_0000, b_z: 32'h0006_0000, scale: '0};
    pending_reqs.push_back(rq);
    for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(random_req());

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_rsps.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d requests over all ten operations and undefined codes, %0d checked, %0d faults.",
             sent, checked, fault_seen);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding", expected_rsps.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
